>>> sv/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

  localparam int PatternLenDef = 32;
  localparam int MaxTextDef    = 256;
  localparam int MaxStarsDef   = 10;

  localparam logic [7:0] STAR_CH  = 8'h2A;
  localparam logic [7:0] QMARK_CH = 8'h3F;
  localparam logic [3:0] STAR_SAT = 4'hF;

  typedef enum logic {
    FUNC_PATTERN = 1'b0,
    FUNC_TEXT    = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [15:0] value;
    logic        first;
    logic        last;
  } item_t;

  typedef struct packed {
    logic done_res;
    logic matched;
    logic error;
  } result_t;

  typedef struct packed {
    logic pat_item;
    logic text_item;
    logic first;
    logic last;
    logic zero_unit;
  } wgm_ctl_t;

endpackage

>>> sv/wgm_pattern.sv
// Pattern store, length, star count and per-position match masks.
module wgm_pattern
  import wgm_pkg::*;
#(
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int MAX_STARS   = MaxStarsDef,
  localparam int LEN_W      = $clog2(PATTERN_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wgm_ctl_t               ctl,
  input  logic [15:0]            value,
  output logic [LEN_W-1:0]       len,
  output logic [LEN_W-1:0]       lead_run,
  output logic [PATTERN_LEN-1:0] star_mask,
  output logic [PATTERN_LEN-1:0] adv_mask,
  output logic                   error
);

  localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

  logic [7:0]       store [PATTERN_LEN];
  logic [LEN_W-1:0] pattern_length;
  logic [3:0]       star_count;
  logic             overflow;
  logic [LEN_W-1:0] lead;
  logic             lead_open;

  logic [7:0]       byte_in;
  logic             is_star;
  logic [LEN_W-1:0] base_len;
  logic [3:0]       base_stars;
  logic [LEN_W-1:0] base_lead;
  logic             base_ovf;
  logic             base_open;
  logic             full;
  logic             store_en;

  assign byte_in    = value[7:0];
  assign is_star    = (byte_in == STAR_CH);
  assign base_len   = ctl.first ? '0 : pattern_length;
  assign base_stars = ctl.first ? '0 : star_count;
  assign base_lead  = ctl.first ? '0 : lead;
  assign base_ovf   = ctl.first ? 1'b0 : overflow;
  assign base_open  = ctl.first ? 1'b1 : lead_open;
  assign full       = (base_len >= LEN_W'(PATTERN_LEN));
  assign store_en   = ctl.pat_item && (byte_in != 8'h00) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      star_count     <= '0;
      overflow       <= 1'b0;
      lead           <= '0;
      lead_open      <= 1'b1;
    end else if (ctl.pat_item) begin
      pattern_length <= base_len;
      star_count     <= base_stars;
      overflow       <= base_ovf;
      lead           <= base_lead;
      lead_open      <= base_open;
      if (byte_in != 8'h00) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          pattern_length <= base_len + LEN_W'(1);
          if (is_star && base_stars < STAR_SAT) begin
            star_count <= base_stars + 4'd1;
          end
          if (is_star && base_open) begin
            lead <= base_lead + LEN_W'(1);
          end else if (!is_star) begin
            lead_open <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      store[base_len[IDX_W-1:0]] <= byte_in;
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      logic in_use;
      in_use       = (LEN_W'(i) < pattern_length);
      star_mask[i] = in_use && (store[i] == STAR_CH);
      adv_mask[i]  = in_use && ((store[i] == QMARK_CH) ||
                     (!store[i][7] && ({8'h00, store[i]} == value)));
    end
  end

  assign len      = pattern_length;
  assign lead_run = lead;
  assign error    = overflow || (star_count > 4'(MAX_STARS));

endmodule

>>> sv/wgm_nfa.sv
// Active-position vector, text counter and verdict logic.
module wgm_nfa
  import wgm_pkg::*;
#(
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int MAX_TEXT    = MaxTextDef,
  localparam int LEN_W      = $clog2(PATTERN_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wgm_ctl_t               ctl,
  input  logic [LEN_W-1:0]       len,
  input  logic [LEN_W-1:0]       lead_run,
  input  logic [PATTERN_LEN-1:0] star_mask,
  input  logic [PATTERN_LEN-1:0] adv_mask,
  output logic                   done,
  output logic                   verdict
);

  localparam int CNT_W = $clog2(MAX_TEXT + 1);
  localparam int LVL   = $clog2(PATTERN_LEN + 1);

  logic [PATTERN_LEN:0] active;
  logic [CNT_W-1:0]     text_count;
  logic                 finished;

  logic [PATTERN_LEN:0] start_vec;
  logic [PATTERN_LEN:0] act_cur;
  logic [PATTERN_LEN:0] nx_raw;
  logic [PATTERN_LEN:0] nx;
  logic [PATTERN_LEN:0] g [LVL+1];
  logic [PATTERN_LEN:0] p [LVL+1];
  logic [CNT_W-1:0]     cnt_inc;
  logic                 open_now;
  logic                 step;

  always_comb begin
    for (int i = 0; i <= PATTERN_LEN; i++) begin
      start_vec[i] = (LEN_W'(i) <= lead_run);
    end
  end

  assign open_now = ctl.first || !finished;
  assign act_cur  = ctl.first ? start_vec : active;
  assign nx_raw   = {1'b0, act_cur[PATTERN_LEN-1:0] & star_mask} |
                    {act_cur[PATTERN_LEN-1:0] & adv_mask, 1'b0};

  // prefix closure: an active star also activates the position after it
  always_comb begin
    g[0] = nx_raw;
    p[0] = {star_mask, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i <= PATTERN_LEN; i++) begin
        if (i >= (1 << l)) begin
          g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1<<l)]);
          p[l+1][i] = p[l][i] & p[l][i-(1<<l)];
        end else begin
          g[l+1][i] = g[l][i];
          p[l+1][i] = p[l][i];
        end
      end
    end
  end
  assign nx = g[LVL];

  assign step    = ctl.text_item && open_now && !ctl.zero_unit;
  assign cnt_inc = (ctl.first ? '0 : text_count) + CNT_W'(1);

  always_comb begin
    done    = 1'b0;
    verdict = 1'b0;
    if (ctl.text_item && open_now) begin
      if (ctl.zero_unit) begin
        done    = 1'b1;
        verdict = act_cur[len];
      end else if (ctl.last || cnt_inc >= CNT_W'(MAX_TEXT)) begin
        done    = 1'b1;
        verdict = nx[len];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      text_count <= '0;
      finished   <= 1'b1;
    end else if (ctl.pat_item) begin
      finished <= 1'b1;
    end else if (ctl.text_item && open_now) begin
      finished <= done;
      if (step) begin
        active     <= nx;
        text_count <= cnt_inc;
      end else if (ctl.first) begin
        active     <= start_vec;
        text_count <= '0;
      end
    end
  end

endmodule

>>> sv/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: handshakes, input and result registers.
//
// Channels: item (valid/ready, item_t) carries pattern bytes (func = 0) and
// 16-bit text units (func = 1); res (valid/ready, result_t) returns one
// result transaction for every item transaction, in order. Load a pattern
// with first set on its opening byte, then stream a string with first set
// on its opening unit. A string ends at a zero unit, at a unit with last
// set, or after MAX_TEXT units; that transaction's result has done_res set
// with matched and error. All other results are all zero.
// Path: an item accepted into the input register reaches res through the
// result register. Throughput: one item per cycle while res is not
// stalled; the star closure over all pattern positions is a prefix tree
// of ceil(log2(PATTERN_LEN + 1)) levels between the two registers.
// Reset: both registers empty, pattern empty, no string open; the pattern
// store holds garbage until written. When res stalls, the result register
// holds and the input register still takes one item; item_ready then drops
// until the result is taken.
module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int MAX_TEXT    = MaxTextDef,
  parameter int MAX_STARS   = MaxStarsDef
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int LEN_W = $clog2(PATTERN_LEN + 1);

  item_t   item_q;
  logic    item_vld;
  logic    advance;
  logic    fire;
  wgm_ctl_t ctl;

  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       lead_run;
  logic [PATTERN_LEN-1:0] star_mask;
  logic [PATTERN_LEN-1:0] adv_mask;
  logic                   error;
  logic                   done;
  logic                   verdict;
  result_t                res_next;

  assign advance    = !res_valid || res_ready;
  assign fire       = item_vld && advance;
  assign item_ready = !item_vld || advance;

  assign ctl.pat_item  = fire && (item_q.func == FUNC_PATTERN);
  assign ctl.text_item = fire && (item_q.func == FUNC_TEXT);
  assign ctl.first     = item_q.first;
  assign ctl.last      = item_q.last;
  assign ctl.zero_unit = (item_q.value == 16'h0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item_ready) begin
      item_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  wgm_pattern #(
    .PATTERN_LEN(PATTERN_LEN),
    .MAX_STARS  (MAX_STARS)
  ) u_pattern (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .value    (item_q.value),
    .len      (len),
    .lead_run (lead_run),
    .star_mask(star_mask),
    .adv_mask (adv_mask),
    .error    (error)
  );

  wgm_nfa #(
    .PATTERN_LEN(PATTERN_LEN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_nfa (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .len      (len),
    .lead_run (lead_run),
    .star_mask(star_mask),
    .adv_mask (adv_mask),
    .done     (done),
    .verdict  (verdict)
  );

  assign res_next.done_res = done;
  assign res_next.matched  = done && verdict && !error;
  assign res_next.error    = done && error;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && item_vld |-> !item_ready)
    else $error("input taken while both stages are full");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.matched && res.error) && (res.done_res || !(res.matched || res.error)))
    else $error("inconsistent result flags");

  a_item_flows: assert property (@(posedge clk) disable iff (rst)
    item_vld && advance |=> res_valid)
    else $error("processed item produced no result");

endmodule

>>> tb/sv/wildcard_glob_matcher_test.sv
// Self-checking testbench for the wildcard glob matcher with a built-in glob predictor.
module wildcard_glob_matcher_test;
  import wgm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_CAP    = PatternLenDef;
  localparam int TEXT_CAP   = MaxTextDef;
  localparam int STAR_LIMIT = MaxStarsDef;
  localparam int RAND_ITEMS = 2000;
  localparam int PLAN_ROWS  = 30;

  localparam result_t R_IDLE = 3'b000;
  localparam result_t R_HIT  = 3'b110;
  localparam result_t R_MISS = 3'b100;
  localparam result_t R_ERR  = 3'b101;

  typedef struct {
    item_t   it;
    int      reps;
    bit      pin;
    result_t want;
  } plan_row_t;

  logic    clk;
  logic    rst        = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item       = '0;
  logic    res_valid;
  logic    res_ready  = 1'b0;
  result_t res;

  // per-transaction pinned expectation from the directed table
  bit      item_pin   = 1'b0;
  result_t item_want  = R_IDLE;

  // matcher state mirror
  logic [7:0]       pat_mem[PAT_CAP];
  int unsigned      pat_len      = 0;
  logic [3:0]       star_tally   = '0;
  bit               pat_overflow = 1'b0;
  bit [PAT_CAP:0]   live_pos     = '0;
  int unsigned      unit_count   = 0;
  bit               text_closed  = 1'b1;

  result_t verdicts_due[$];
  logic [7:0] gen_pat[$];
  plan_row_t plan[PLAN_ROWS];

  int  errors = 0;
  int  fed = 0;
  int  n_verdicts = 0;
  int  n_matches = 0;
  int  n_errflags = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  wildcard_glob_matcher DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic item_t pkt(logic f, logic [15:0] v, logic fi, logic la);
    item_t p;
    p.func  = f;
    p.value = v;
    p.first = fi;
    p.last  = la;
    return p;
  endfunction

  function automatic plan_row_t row(logic f, logic [15:0] v, logic fi, logic la,
                                    int reps, bit pin, result_t want);
    plan_row_t r;
    r.it   = pkt(f, v, fi, la);
    r.reps = reps;
    r.pin  = pin;
    r.want = want;
    return r;
  endfunction

  function automatic bit [PAT_CAP:0] star_closure(bit [PAT_CAP:0] v);
    for (int i = 0; i < pat_len; i++)
      if (v[i] && pat_mem[i] == STAR_CH) v[i+1] = 1'b1;
    return v;
  endfunction

  function automatic result_t glob_step(item_t it);
    logic [7:0]     b;
    bit [PAT_CAP:0] nx;
    bit             fin;
    bit             hit;
    result_t        r;
    b   = it.value[7:0];
    fin = 1'b0;
    hit = 1'b0;
    if (it.func == FUNC_PATTERN) begin
      text_closed = 1'b1;
      if (it.first) begin
        pat_len      = 0;
        star_tally   = '0;
        pat_overflow = 1'b0;
      end
      if (b != 8'h00) begin
        if (pat_len >= PAT_CAP) begin
          pat_overflow = 1'b1;
        end else begin
          pat_mem[pat_len] = b;
          pat_len++;
          if (b == STAR_CH && star_tally != STAR_SAT) star_tally++;
        end
      end
    end else begin
      if (it.first) begin
        live_pos    = '0;
        live_pos[0] = 1'b1;
        live_pos    = star_closure(live_pos);
        unit_count  = 0;
        text_closed = 1'b0;
      end
      if (!text_closed) begin
        if (it.value == 16'h0000) begin
          hit = live_pos[pat_len];
          fin = 1'b1;
        end else begin
          nx = '0;
          for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i]) begin
              if (pat_mem[i] == STAR_CH) nx[i] = 1'b1;
              else if (pat_mem[i] == QMARK_CH) nx[i+1] = 1'b1;
              else if (!pat_mem[i][7] && {8'h00, pat_mem[i]} == it.value) nx[i+1] = 1'b1;
            end
          end
          live_pos = star_closure(nx);
          unit_count++;
          if (it.last || unit_count >= TEXT_CAP) begin
            hit = live_pos[pat_len];
            fin = 1'b1;
          end
        end
        if (fin) text_closed = 1'b1;
      end
    end
    r.done_res = fin;
    r.error    = fin && (pat_overflow || star_tally > STAR_LIMIT);
    r.matched  = fin && hit && !r.error;
    return r;
  endfunction

  // acceptance monitor and result checker
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (item_valid && item_ready) begin
        want = glob_step(item);
        if (item_pin) want = item_want;
        verdicts_due.push_back(want);
      end
      if (res_valid && res_ready) begin
        got = res;
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, actual done=%b matched=%b error=%b",
                   $time, got.done_res, got.matched, got.error);
        end else begin
          want = verdicts_due.pop_front();
          if (got.done_res !== want.done_res || got.matched !== want.matched ||
              got.error !== want.error) begin
            errors++;
            $display({"%0t: mismatch, expected done=%b matched=%b error=%b, ",
                      "actual done=%b matched=%b error=%b"},
                     $time, want.done_res, want.matched, want.error,
                     got.done_res, got.matched, got.error);
          end
          if (got.done_res === 1'b1) n_verdicts++;
          if (got.matched === 1'b1) n_matches++;
          if (got.error === 1'b1) n_errflags++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(199) == 0) rx_calm = !rx_calm;
      if (stall == 0 && !rx_calm && $urandom_range(9) == 0)
        stall = ($urandom_range(4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (stall > 0) begin
        res_ready <= 1'b0;
        stall--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_item(item_t it, bit pin, result_t want);
    int gap;
    if ($urandom_range(99) == 0) tx_calm = !tx_calm;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    item_pin   <= pin;
    item_want  <= want;
    do @(posedge clk); while (!item_ready);
    fed++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic push_pat(logic [15:0] v, bit fi);
    if (fi) gen_pat.delete();
    if (v[7:0] != 8'h00 && gen_pat.size() < PAT_CAP) gen_pat.push_back(v[7:0]);
    push_item(pkt(FUNC_PATTERN, v, fi, 1'($urandom_range(1))), 1'b0, R_IDLE);
  endtask

  function automatic logic [15:0] rand_pat_byte(bit heavy);
    int r;
    logic [7:0] hi;
    logic [7:0] lo;
    r  = $urandom_range(99);
    hi = ($urandom_range(9) < 6) ? 8'h00 : 8'($urandom_range(255));
    if ((heavy && r < 60) || r < 20) lo = STAR_CH;
    else if (r < 35) lo = QMARK_CH;
    else if (r < 75) lo = 8'h61 + 8'($urandom_range(2));
    else if (r < 85) lo = 8'h80 | 8'($urandom_range(127));
    else lo = 8'($urandom_range(255));
    return {hi, lo};
  endfunction

  function automatic logic [15:0] rand_unit();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'h0061 + 16'($urandom_range(2));
    if (r < 65) return {8'($urandom_range(1, 255)), 8'h61};
    if (r < 75) return 16'h0080 + 16'($urandom_range(127));
    return 16'($urandom_range(1, 65535));
  endfunction

  task automatic load_pattern();
    int  r;
    int  n;
    bit  heavy;
    logic [15:0] v;
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(0, 8);
    else if (r < 85) n = $urandom_range(9, 20);
    else n = $urandom_range(PAT_CAP - 4, PAT_CAP + 4);
    heavy = ($urandom_range(9) == 0);
    if (n == 0) push_pat({8'($urandom_range(255)), 8'h00}, 1'b1);
    for (int i = 0; i < n; i++) begin
      v = rand_pat_byte(heavy);
      if ($urandom_range(9) == 0) v[7:0] = 8'h00;
      push_pat(v, i == 0);
    end
  endtask

  task automatic stream_text();
    logic [15:0] u[$];
    int r;
    int ending;
    int k;
    r = $urandom_range(99);
    if (r < 3) begin
      k = $urandom_range(TEXT_CAP - 6, TEXT_CAP + 6);
      repeat (k) u.push_back(rand_unit());
    end else if (r < 45) begin
      foreach (gen_pat[j]) begin
        if (gen_pat[j] == STAR_CH) repeat ($urandom_range(0, 3)) u.push_back(rand_unit());
        else if (gen_pat[j] == QMARK_CH) u.push_back(rand_unit());
        else u.push_back({8'h00, gen_pat[j]});
      end
      if (u.size() > 0 && $urandom_range(3) == 0) u[$urandom_range(u.size() - 1)] = rand_unit();
    end else begin
      k = $urandom_range(0, 10);
      repeat (k) u.push_back(rand_unit());
    end
    r = $urandom_range(99);
    ending = (r < 60) ? 0 : (r < 85) ? 1 : 2;
    if (u.size() == 0 && ending == 0) ending = 1;
    foreach (u[i])
      push_item(pkt(FUNC_TEXT, u[i], i == 0, ending == 0 && i == u.size() - 1), 1'b0, R_IDLE);
    if (ending == 1)
      push_item(pkt(FUNC_TEXT, 16'h0000, u.size() == 0, 1'($urandom_range(1))),
                1'b0, R_IDLE);
  endtask

  initial begin
    int r;
    int fed0;
    plan = '{
      row(FUNC_TEXT,    16'h0000, 1, 0, 1,  1, R_HIT),
      row(FUNC_TEXT,    16'h0061, 0, 1, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0061, 1, 1, 1,  1, R_MISS),
      row(FUNC_PATTERN, 16'hFF61, 1, 0, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h1200, 0, 1, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h002A, 0, 0, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h003F, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0061, 1, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0051, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'hFFFF, 0, 1, 1,  0, R_IDLE),
      row(FUNC_PATTERN, 16'h00C1, 1, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h00C1, 1, 1, 1,  1, R_MISS),
      row(FUNC_PATTERN, 16'h8061, 1, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0161, 1, 1, 1,  1, R_MISS),
      row(FUNC_TEXT,    16'h0061, 1, 0, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h0062, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0061, 0, 1, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0061, 1, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0062, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0000, 0, 0, 1,  0, R_IDLE),
      row(FUNC_PATTERN, 16'h002A, 1, 0, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h002A, 0, 0, 9,  1, R_IDLE),
      row(FUNC_TEXT,    16'h007A, 1, 1, 1,  1, R_HIT),
      row(FUNC_PATTERN, 16'h002A, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h007A, 1, 1, 1,  1, R_ERR),
      row(FUNC_PATTERN, 16'h003F, 1, 0, 1,  1, R_IDLE),
      row(FUNC_PATTERN, 16'h003F, 0, 0, 31, 1, R_IDLE),
      row(FUNC_TEXT,    16'h0000, 1, 0, 1,  1, R_MISS),
      row(FUNC_PATTERN, 16'h0078, 0, 0, 1,  1, R_IDLE),
      row(FUNC_TEXT,    16'h0000, 1, 0, 1,  1, R_ERR)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      repeat (plan[i].reps) push_item(plan[i].it, plan[i].pin, plan[i].want);
    drain();

    // directed part leaves a 33-byte request on record; restart generator view
    push_pat(16'h002A, 1'b1);
    fed0 = fed;
    while (fed - fed0 < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 14) begin
        load_pattern();
      end else if (r < 17) begin
        push_pat(rand_pat_byte(1'b0), 1'b0);
      end else if (r < 20) begin
        if ($urandom_range(1)) push_pat(16'($urandom_range(65535)), 1'($urandom_range(1)));
        else push_item(pkt(FUNC_TEXT, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                           1'($urandom_range(1))), 1'b0, R_IDLE);
      end else begin
        stream_text();
      end
      if ($urandom_range(99) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d item transactions; %0d verdicts seen, %0d matches, %0d error flags.",
             fed, n_verdicts, n_matches, n_errflags);
    $display("Covered empty, aborted, ignored and max-length strings, star and store limits.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
sv/wgm_pkg.sv
sv/wgm_pattern.sv
sv/wgm_nfa.sv
sv/wildcard_glob_matcher.sv
tb/sv/wildcard_glob_matcher_test.sv
